// ----- rtl/cad_pkg.sv -----
// Types, constants and helper functions for the checksummed address string decoder.
package cad_pkg;

  typedef enum logic [1:0] {
    KIND_PREFIX,
    KIND_PAYLOAD,
    KIND_STATUS
  } kind_t;

  typedef enum logic [3:0] {
    ERR_OK,
    ERR_BAD_CHAR,
    ERR_DIGIT_PREFIX,
    ERR_MISPLACED_SEP,
    ERR_NO_SEP,
    ERR_MIXED_CASE,
    ERR_BAD_SYMBOL,
    ERR_SHORT,
    ERR_CHECKSUM
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    err_t       error_code;
    logic       last_of_run;
  } item_t;

  localparam int unsigned REM_W    = 40;
  localparam int unsigned SYM_W    = 5;
  localparam int unsigned CHK_SYMS = 8;

  localparam logic [REM_W-1:0] REM_INIT = 40'h00_0000_0001;
  localparam logic [7:0]       CHAR_SEP = 8'h3a;
  localparam logic [7:0]       CASE_BIT = 8'h20;

  localparam logic [REM_W-1:0] GEN_TERMS [SYM_W] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4, 40'hae2eabe2a8, 40'h1e4f43e470
  };

  // Character i of the symbol alphabet sits at bits [255-8i -: 8].
  localparam logic [255:0] ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  // One step of the GF(32) BCH remainder: shift in a symbol, fold back the top one.
  function automatic logic [REM_W-1:0] bch_feed(input logic [REM_W-1:0] rem,
                                                input logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] top;
    logic [REM_W-1:0] r;
    top = rem[REM_W-1 -: SYM_W];
    r   = {rem[REM_W-SYM_W-1:0], sym};
    for (int b = 0; b < SYM_W; b++) begin
      if (top[b]) begin
        r = r ^ GEN_TERMS[b];
      end
    end
    return r;
  endfunction

  // Returns {hit, symbol}; hit is low when the byte is not in the alphabet.
  function automatic logic [SYM_W:0] sym_lookup(input logic [7:0] ch);
    logic [7:0]       lc;
    logic             hit;
    logic [SYM_W-1:0] sym;
    lc  = ((ch >= 8'h41) && (ch <= 8'h5a)) ? (ch | CASE_BIT) : ch;
    hit = 1'b0;
    sym = '0;
    for (int i = 0; i < 32; i++) begin
      if (ALPHABET[255 - 8*i -: 8] == lc) begin
        hit = 1'b1;
        sym = SYM_W'(i);
      end
    end
    return {hit, sym};
  endfunction

endpackage

// ----- rtl/checksummed_address_string_decoder.sv -----
// Top level: checksummed address string decoder with a three-entry result queue.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------------------------
//  in_      | in  | tvalid/tready     | tdata = character, tlast = final_char
//  out_     | out | tvalid/tready     | tdata = value, error_code; tuser = kind;
//           |     |                   | tlast = last_of_run
//
// One character is taken per cycle while in_tready is high; the decode, remainder
// update and delay line update all settle in the accept cycle and the results land
// in the queue. A final character that also emits a prefix byte or releases a
// payload symbol gives two results, which leave the queue one after the other;
// in_tready drops while fewer than two queue slots are free. Reset (rst_n low) is
// synchronous. An output stall holds the queue head and backs up into in_tready
// once fewer than two queue slots are free.
module checksummed_address_string_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value, [11:8] error_code, [15:12] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);
  import cad_pkg::*;

  // decoder state
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             sep_r, sep_nxt;
  logic             first_r, first_nxt;
  logic             lower_r, lower_nxt;
  logic             upper_r, upper_nxt;
  err_t             ferr_r, ferr_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic [SYM_W-1:0] dly_r [CHK_SYMS];
  logic [SYM_W-1:0] dly_nxt [CHK_SYMS];

  // result queue
  item_t            q_r [3];
  logic [1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  logic             accept, pop;
  logic [7:0]       ch;
  logic             is_lower, is_upper, is_digit, is_sep;
  logic [SYM_W:0]   lk;
  logic [SYM_W-1:0] feed_sym;
  logic             emit_prefix, emit_payload;
  err_t             status;
  item_t            item0, item1;
  logic [1:0]       push_n;
  logic [1:0]       wr1;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign ch       = in_tdata;
  assign is_lower = (ch >= 8'h61) && (ch <= 8'h7a);
  assign is_upper = (ch >= 8'h41) && (ch <= 8'h5a);
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_sep   = (ch == CHAR_SEP);
  assign lk       = sym_lookup(ch);

  always_comb begin
    sep_nxt      = sep_r;
    first_nxt    = 1'b0;
    lower_nxt    = lower_r | is_lower;
    upper_nxt    = upper_r | is_upper;
    ferr_nxt     = ferr_r;
    cnt_nxt      = cnt_r;
    feed_sym     = '0;
    emit_prefix  = 1'b0;
    emit_payload = 1'b0;
    for (int i = 0; i < CHK_SYMS; i++) begin
      dly_nxt[i] = dly_r[i];
    end

    if (!sep_r) begin
      if (is_sep) begin
        if (first_r && (ferr_r == ERR_OK || ferr_r == ERR_BAD_SYMBOL)) begin
          ferr_nxt = ERR_MISPLACED_SEP;
        end
        sep_nxt = 1'b1;
      end else begin
        if (ferr_r == ERR_OK || ferr_r == ERR_BAD_SYMBOL) begin
          if (is_digit) begin
            ferr_nxt = ERR_DIGIT_PREFIX;
          end else if (!is_lower && !is_upper) begin
            ferr_nxt = ERR_BAD_CHAR;
          end
        end
        feed_sym    = ch[SYM_W-1:0];
        emit_prefix = 1'b1;
      end
    end else begin
      if (is_sep) begin
        if (ferr_r == ERR_OK || ferr_r == ERR_BAD_SYMBOL) begin
          ferr_nxt = ERR_MISPLACED_SEP;
        end
      end else if (!is_lower && !is_upper && !is_digit) begin
        if (ferr_r == ERR_OK || ferr_r == ERR_BAD_SYMBOL) begin
          ferr_nxt = ERR_BAD_CHAR;
        end
      end else if (lk[SYM_W]) begin
        feed_sym = lk[SYM_W-1:0];
      end else if (ferr_r == ERR_OK) begin
        ferr_nxt = ERR_BAD_SYMBOL;
      end

      // Once the line is full, release the oldest symbol and shift.
      if (cnt_r[3]) begin
        emit_payload = 1'b1;
        for (int i = 0; i < CHK_SYMS - 1; i++) begin
          dly_nxt[i] = dly_r[i+1];
        end
        dly_nxt[CHK_SYMS-1] = feed_sym;
      end else begin
        dly_nxt[cnt_r[2:0]] = feed_sym;
        cnt_nxt             = cnt_r + 4'd1;
      end
    end

    rem_nxt = bch_feed(rem_r, feed_sym);

    status = ferr_nxt;
    if (status == ERR_OK || status == ERR_BAD_SYMBOL) begin
      if (!sep_nxt) begin
        status = ERR_NO_SEP;
      end else if (lower_nxt && upper_nxt) begin
        status = ERR_MIXED_CASE;
      end
    end
    if (status == ERR_OK) begin
      if (!cnt_nxt[3]) begin
        status = ERR_SHORT;
      end else if (rem_nxt != REM_INIT) begin
        status = ERR_CHECKSUM;
      end
    end
  end

  // Build up to two results for the accepted character.
  always_comb begin
    item_t data_item, stat_item;
    data_item.kind        = emit_prefix ? KIND_PREFIX : KIND_PAYLOAD;
    data_item.value       = emit_prefix ? (ch | CASE_BIT) : {3'b000, dly_r[0]};
    data_item.error_code  = ERR_OK;
    data_item.last_of_run = !in_tlast;
    stat_item.kind        = KIND_STATUS;
    stat_item.value       = '0;
    stat_item.error_code  = status;
    stat_item.last_of_run = 1'b1;

    if (emit_prefix || emit_payload) begin
      item0  = data_item;
      item1  = stat_item;
      push_n = in_tlast ? 2'd2 : 2'd1;
    end else begin
      item0  = stat_item;
      item1  = stat_item;
      push_n = in_tlast ? 2'd1 : 2'd0;
    end
    if (!accept) begin
      push_n = 2'd0;
    end
  end

  assign in_tready = (count_r <= 2'd1);
  assign accept    = in_tvalid && in_tready;
  assign out_tvalid = (count_r != 2'd0);
  assign pop       = out_tvalid && out_tready;
  assign wr1       = inc3(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push_n == 2'd1) begin
      wr_ptr_nxt = wr1;
    end else if (push_n == 2'd2) begin
      wr_ptr_nxt = inc3(wr1);
    end
    rd_ptr_nxt = pop ? inc3(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + push_n - {1'b0, pop};
  end

  assign out_tdata = {4'b0000, q_r[rd_ptr_r].error_code, q_r[rd_ptr_r].value};
  assign out_tuser = q_r[rd_ptr_r].kind;
  assign out_tlast = q_r[rd_ptr_r].last_of_run;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= REM_INIT;
      sep_r    <= 1'b0;
      first_r  <= 1'b1;
      lower_r  <= 1'b0;
      upper_r  <= 1'b0;
      ferr_r   <= ERR_OK;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      if (accept) begin
        if (in_tlast) begin
          // end of string: start over for the next one
          rem_r   <= REM_INIT;
          sep_r   <= 1'b0;
          first_r <= 1'b1;
          lower_r <= 1'b0;
          upper_r <= 1'b0;
          ferr_r  <= ERR_OK;
          cnt_r   <= '0;
        end else begin
          rem_r   <= rem_nxt;
          sep_r   <= sep_nxt;
          first_r <= first_nxt;
          lower_r <= lower_nxt;
          upper_r <= upper_nxt;
          ferr_r  <= ferr_nxt;
          cnt_r   <= cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < CHK_SYMS; i++) begin
        dly_r[i] <= dly_nxt[i];
      end
    end
    if (push_n != 2'd0) begin
      q_r[wr_ptr_r] <= item0;
    end
    if (push_n == 2'd2) begin
      q_r[wr1] <= item1;
    end
  end

endmodule

// ----- tb/checksummed_address_string_decoder_tb.sv -----
// Self-checking testbench for the checksummed address string decoder.
`timescale 1ns / 1ps

module checksummed_address_string_decoder_tb;
  import cad_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  // Character i of the symbol alphabet sits at bits [8*(31-i) +: 8].
  localparam logic [255:0] B32_CHARS = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  checksummed_address_string_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Decoder state mirror
  logic [39:0] rem;
  logic        sep_seen;
  logic        first_pos;
  logic        saw_lo;
  logic        saw_up;
  err_t        first_err;
  int          sym_cnt;
  logic [4:0]  sym_delay [8];

  item_t       expected_results [$];
  logic [7:0]  str_q [$];

  bit          idle_en = 1'b1;
  int          out_hold = 0;
  int unsigned cycles = 0;
  int          chars_sent = 0;
  int          strings_sent = 0;
  int          results_seen = 0;
  int          fail_count = 0;
  int          status_seen [16];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [39:0] bch_step(input logic [39:0] r, input logic [4:0] d);
    logic [39:0] nr;
    nr = {r[34:0], d};
    if (r[35]) nr = nr ^ 40'h98f2bc8e61;
    if (r[36]) nr = nr ^ 40'h79b76d99e2;
    if (r[37]) nr = nr ^ 40'hf33e5fb3c4;
    if (r[38]) nr = nr ^ 40'hae2eabe2a8;
    if (r[39]) nr = nr ^ 40'h1e4f43e470;
    return nr;
  endfunction

  function automatic int char_to_sym(input logic [7:0] c);
    logic [7:0] lc;
    int         hit;
    lc  = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
    hit = -1;
    for (int i = 0; i < 32; i++) begin
      if (B32_CHARS[8*(31-i) +: 8] == lc) hit = i;
    end
    return hit;
  endfunction

  function automatic logic [7:0] sym_char(input logic [4:0] s, input bit upper);
    logic [7:0] c;
    c = B32_CHARS[8*(31 - int'(s)) +: 8];
    if (upper && c >= "a" && c <= "z") c = c & 8'hdf;
    return c;
  endfunction

  function automatic void clear_decoder();
    rem       = 40'h1;
    sep_seen  = 1'b0;
    first_pos = 1'b1;
    saw_lo    = 1'b0;
    saw_up    = 1'b0;
    first_err = ERR_OK;
    sym_cnt   = 0;
    for (int i = 0; i < 8; i++) sym_delay[i] = 5'd0;
  endfunction

  // Scan errors keep string order and outrank a bad symbol.
  function automatic void note_scan_error(input err_t code);
    if (first_err == ERR_OK || first_err == ERR_BAD_SYMBOL) first_err = code;
  endfunction

  function automatic item_t result_of(input kind_t k, input logic [7:0] v, input err_t e);
    item_t r;
    r.kind        = k;
    r.value       = v;
    r.error_code  = e;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void predict_char(input logic [7:0] c, input logic fin);
    logic       lo;
    logic       up;
    logic       dg;
    int         s;
    logic [4:0] sym;
    err_t       e;
    item_t      res [2];
    int         n;
    lo = (c >= "a" && c <= "z");
    up = (c >= "A" && c <= "Z");
    dg = (c >= "0" && c <= "9");
    n  = 0;
    if (lo) saw_lo = 1'b1;
    if (up) saw_up = 1'b1;
    if (!sep_seen) begin
      if (c == ":") begin
        if (first_pos) note_scan_error(ERR_MISPLACED_SEP);
        sep_seen = 1'b1;
        rem = bch_step(rem, 5'd0);
      end else begin
        if (dg) note_scan_error(ERR_DIGIT_PREFIX);
        else if (!lo && !up) note_scan_error(ERR_BAD_CHAR);
        rem = bch_step(rem, c[4:0]);
        res[n] = result_of(KIND_PREFIX, c | 8'h20, ERR_OK);
        n++;
      end
    end else begin
      s = -1;
      if (c == ":") note_scan_error(ERR_MISPLACED_SEP);
      else if (!lo && !up && !dg) note_scan_error(ERR_BAD_CHAR);
      else begin
        s = char_to_sym(c);
        if (s < 0 && first_err == ERR_OK) first_err = ERR_BAD_SYMBOL;
      end
      sym = (s < 0) ? 5'd0 : 5'(s);
      rem = bch_step(rem, sym);
      // Hold the last eight symbols back: they are the checksum.
      if (sym_cnt >= 8) begin
        res[n] = result_of(KIND_PAYLOAD, {3'b000, sym_delay[0]}, ERR_OK);
        n++;
        for (int i = 0; i < 7; i++) sym_delay[i] = sym_delay[i+1];
        sym_delay[7] = sym;
      end else begin
        sym_delay[sym_cnt] = sym;
        sym_cnt++;
      end
    end
    first_pos = 1'b0;
    if (fin) begin
      e = first_err;
      if (e == ERR_OK || e == ERR_BAD_SYMBOL) begin
        if (!sep_seen) e = ERR_NO_SEP;
        else if (saw_lo && saw_up) e = ERR_MIXED_CASE;
      end
      if (e == ERR_OK) begin
        if (sym_cnt < 8) e = ERR_SHORT;
        else if (rem != 40'h1) e = ERR_CHECKSUM;
      end
      res[n] = result_of(KIND_STATUS, 8'h00, e);
      n++;
      clear_decoder();
    end
    if (n > 0) res[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
  endfunction

  function automatic void check_result();
    item_t      want;
    logic [3:0] got_err;
    got_err = out_tdata[11:8];
    results_seen++;
    if (out_tuser == KIND_STATUS) status_seen[got_err]++;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] unexpected result: kind=%0d value=%02h err=%0d last=%0b",
                 $realtime, out_tuser, out_tdata[7:0], got_err, out_tlast);
    end else begin
      want = expected_results.pop_front();
      if (out_tuser !== want.kind || out_tdata[7:0] !== want.value ||
          got_err !== want.error_code || out_tlast !== want.last_of_run ||
          out_tdata[15:12] !== 4'h0) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"[%0t] mismatch: exp kind=%0d value=%02h err=%0d last=%0b",
                    " | got kind=%0d value=%02h err=%0d last=%0b pad=%0h"},
                   $realtime, want.kind, want.value, want.error_code, want.last_of_run,
                   out_tuser, out_tdata[7:0], got_err, out_tlast, out_tdata[15:12]);
      end
    end
  endfunction

  // Predict on each input transfer, then check each output transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_char(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output backpressure in random bursts.
  always @(posedge clk) begin
    if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_hold   <= $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_char(str_q[i], i == str_q.size() - 1);
    strings_sent++;
  endtask

  // Send up to eight bytes packed left to right into a literal.
  task automatic send_text(input logic [63:0] t, input int len);
    str_q.delete();
    for (int i = 0; i < len; i++) str_q.push_back(t[8*(len-1-i) +: 8]);
    send_string();
  endtask

  // Build prefix, separator, payload and a matching checksum into str_q.
  task automatic build_valid(input int plen, input int dlen, input bit upper);
    logic [39:0] r;
    logic [7:0]  ch;
    logic [4:0]  s;
    str_q.delete();
    r = 40'h1;
    for (int i = 0; i < plen; i++) begin
      ch = 8'h61 + 8'($urandom_range(0, 25));
      if (upper) ch = ch & 8'hdf;
      r = bch_step(r, ch[4:0]);
      str_q.push_back(ch);
    end
    str_q.push_back(":");
    r = bch_step(r, 5'd0);
    for (int i = 0; i < dlen; i++) begin
      s = 5'($urandom_range(0, 31));
      r = bch_step(r, s);
      str_q.push_back(sym_char(s, upper));
    end
    for (int i = 0; i < 8; i++) r = bch_step(r, 5'd0);
    r = r ^ 40'h1;
    for (int k = 0; k < 8; k++) str_q.push_back(sym_char(r[39-5*k -: 5], upper));
  endtask

  function automatic int pick_payload_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 34);
    return $urandom_range(0, 10);
  endfunction

  task automatic test_directed_cases();
    send_text(64'(":"), 1);               // separator first
    send_text(64'("Z"), 1);               // no separator
    send_text(64'({"a", 8'hff}), 2);      // bad byte in prefix, still emitted
    send_text(64'("9:"), 2);              // digit in prefix
    send_text(64'({"a:", 8'h00}), 3);     // bad byte after separator
    send_text(64'("a:b"), 3);             // letter outside alphabet
    send_text(64'("a:Q"), 3);             // mixed case
    send_text(64'("a:q"), 3);             // too few symbols
    send_text(64'("a::"), 3);             // second separator
  endtask

  task automatic test_valid_strings(input int upto);
    while (chars_sent < upto) begin
      build_valid($urandom_range(1, 6), pick_payload_len(), $urandom_range(0, 3) == 0);
      send_string();
    end
  endtask

  task automatic test_corrupted_strings(input int upto);
    int         plen;
    int         p;
    int         s;
    int         keep;
    bit         upper;
    logic [7:0] bad_syms [7];
    bad_syms = '{"b", "i", "o", "1", "B", "I", "O"};
    while (chars_sent < upto) begin
      plen  = $urandom_range(1, 6);
      upper = $urandom_range(0, 3) == 0;
      build_valid(plen, pick_payload_len(), upper);
      p = $urandom_range(plen + 1, str_q.size() - 1);
      case ($urandom_range(0, 8))
        0: begin
          // swap one symbol for another: checksum must catch it
          s = char_to_sym(str_q[p]);
          s = (s + $urandom_range(1, 31)) % 32;
          str_q[p] = sym_char(5'(s), upper);
        end
        1: str_q[0] = str_q[0] ^ 8'h20;
        2: str_q[$urandom_range(0, plen - 1)] = 8'h30 + 8'($urandom_range(0, 9));
        3: str_q[p] = ":";
        4: str_q[p] = bad_syms[$urandom_range(0, 6)];
        5: str_q[$urandom_range(0, str_q.size() - 1)] = 8'($urandom_range(0, 255));
        6: str_q.delete(plen);
        7: begin
          keep = plen + 1 + $urandom_range(0, 7);
          while (str_q.size() > keep) void'(str_q.pop_back());
        end
        default: str_q.push_front(":");
      endcase
      send_string();
    end
  endtask

  task automatic test_byte_noise(input int upto);
    int len;
    while (chars_sent < upto) begin
      len = $urandom_range(1, 12);
      str_q.delete();
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0: str_q.push_back(":");
          1: str_q.push_back(sym_char(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1))));
          default: str_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      send_string();
    end
  endtask

  // Back-to-back strings with no gaps on either side.
  task automatic test_streaming_tail(input int upto);
    idle_en <= 1'b0;
    while (chars_sent < upto) begin
      build_valid($urandom_range(1, 6), pick_payload_len(), 1'b0);
      if ($urandom_range(0, 2) == 0) str_q[$urandom_range(0, str_q.size() - 1)] = 8'h31;
      send_string();
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) status_seen[i] = 0;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_valid_strings(230);
    test_corrupted_strings(420);
    test_byte_noise(480);
    test_streaming_tail(560);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d characters in %0d strings, checked %0d results, %0d failures.",
             chars_sent, strings_sent, results_seen, fail_count);
    $display("Status results: ok=%0d checksum=%0d short=%0d mixed=%0d other=%0d",
             status_seen[ERR_OK], status_seen[ERR_CHECKSUM], status_seen[ERR_SHORT],
             status_seen[ERR_MIXED_CASE],
             status_seen[ERR_BAD_CHAR] + status_seen[ERR_DIGIT_PREFIX] +
             status_seen[ERR_MISPLACED_SEP] + status_seen[ERR_NO_SEP] +
             status_seen[ERR_BAD_SYMBOL]);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cad_pkg.sv
rtl/checksummed_address_string_decoder.sv
tb/checksummed_address_string_decoder_tb.sv
